>>> rtl/pcbr_pkg.sv
package pcbr_pkg;

	// Default build: 64 buffered points of 24-bit signed coordinates.
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 24;

	// Offset selection held in the configuration register.
	localparam logic OFFSET_CENTRE = 1'b0;
	localparam logic OFFSET_MIN    = 1'b1;

	// Depth of the result queue at the back end.
	localparam int OUT_DEPTH = 4;

	// Replay sequencer states.
	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	// Control part of one cloud job handed from the front to the back.
	typedef struct packed {
		logic bank;
		logic dropped;
		logic mode;
	} job_flags_t;

endpackage

>>> rtl/pcbr_store.sv
module pcbr_store #(
	parameter int ADDR_W = 7,
	parameter int DATA_W = 72
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// One write port for the front end, one registered read port for the replay.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/pcbr_jobq.sv
module pcbr_jobq #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output logic [DATA_W-1:0] head
);

	// Two entries, one for each buffer bank.
	logic [DATA_W-1:0] entry_q [2];
	logic              wptr_q;
	logic              rptr_q;
	logic [1:0]        cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = entry_q[rptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Job descriptors themselves need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/pcbr_front.sv
module pcbr_front #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 24,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] in_x,
	input  logic signed [COORD_BITS-1:0] in_y,
	input  logic signed [COORD_BITS-1:0] in_z,
	input  logic                         in_last,
	input  logic                         cfg_valid,
	input  logic                         cfg_data,
	input  logic                         job_full,
	output logic                         job_push,
	output pcbr_pkg::job_flags_t         job_flags,
	output logic [CNT_W-1:0]             job_count,
	output logic [3*COORD_BITS-1:0]      job_lo,
	output logic [3*COORD_BITS-1:0]      job_hi,
	output logic                         wr_en,
	output logic [AW:0]                  wr_addr,
	output logic [3*COORD_BITS-1:0]      wr_data
);

	import pcbr_pkg::*;

	logic [CNT_W-1:0]             cnt_q;
	logic                         dropped_q;
	logic                         bank_q;
	logic                         mode_q;
	logic signed [COORD_BITS-1:0] lo_q [3];
	logic signed [COORD_BITS-1:0] hi_q [3];
	logic signed [COORD_BITS-1:0] pt   [3];
	logic signed [COORD_BITS-1:0] lo_nx [3];
	logic signed [COORD_BITS-1:0] hi_nx [3];
	logic                         accept;
	logic                         stored;
	logic                         first;

	// The front only stalls when both buffer banks hold clouds not yet fully replayed.
	assign full   = job_full;
	assign accept = push & ~job_full;
	assign stored = (cnt_q < CNT_W'(MAX_POINTS));
	assign first  = (cnt_q == '0);

	assign pt[0] = in_x;
	assign pt[1] = in_y;
	assign pt[2] = in_z;

	// Bounding box including the incoming item, if it is kept.
	for (genvar a = 0; a < 3; a++) begin : g_axis
		always_comb begin
			lo_nx[a] = lo_q[a];
			hi_nx[a] = hi_q[a];
			if (stored && (first || pt[a] < lo_q[a])) begin
				lo_nx[a] = pt[a];
			end
			if (stored && (first || pt[a] > hi_q[a])) begin
				hi_nx[a] = pt[a];
			end
		end

		always_ff @(posedge clk) begin
			if (accept) begin
				lo_q[a] <= lo_nx[a];
				hi_q[a] <= hi_nx[a];
			end
		end
	end

	// Buffer write into the bank that the current cloud owns.
	assign wr_en   = accept & stored;
	assign wr_addr = {bank_q, cnt_q[AW-1:0]};
	assign wr_data = {in_x, in_y, in_z};

	// A last item closes the cloud and hands its job to the back end.
	assign job_push        = accept & in_last;
	assign job_flags.bank    = bank_q;
	assign job_flags.dropped = dropped_q | ~stored;
	assign job_flags.mode    = mode_q;
	assign job_count = stored ? CNT_W'(cnt_q + 1'b1) : cnt_q;
	assign job_lo    = {lo_nx[0], lo_nx[1], lo_nx[2]};
	assign job_hi    = {hi_nx[0], hi_nx[1], hi_nx[2]};

	// Cloud bookkeeping and the offset mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			bank_q    <= 1'b0;
			mode_q    <= OFFSET_CENTRE;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (accept) begin
				if (in_last) begin
					cnt_q     <= '0;
					dropped_q <= 1'b0;
					bank_q    <= ~bank_q;
				end else begin
					if (stored) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
					end
					dropped_q <= dropped_q | ~stored;
				end
			end
		end
	end

endmodule

>>> rtl/pcbr_back.sv
module pcbr_back #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 24,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	input  pcbr_pkg::job_flags_t         job_flags,
	input  logic [CNT_W-1:0]             job_count,
	input  logic [3*COORD_BITS-1:0]      job_lo,
	input  logic [3*COORD_BITS-1:0]      job_hi,
	output logic                         job_pop,
	output logic                         rd_en,
	output logic [AW:0]                  rd_addr,
	input  logic [3*COORD_BITS-1:0]      rd_data,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS:0]   out_x,
	output logic signed [COORD_BITS:0]   out_y,
	output logic signed [COORD_BITS:0]   out_z,
	output logic                         out_last,
	output logic                         dropped_points
);

	import pcbr_pkg::*;

	localparam int CB   = COORD_BITS;
	localparam int OW   = 3 * (CB + 1) + 2;
	localparam int OPW  = $clog2(OUT_DEPTH);
	localparam int OCW  = $clog2(OUT_DEPTH + 1);

	back_state_t             state_q;
	back_state_t             state_nx;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    bank_q;
	logic                    dropped_q;
	logic signed [CB:0]      off_q  [3];
	logic signed [CB:0]      off_nx [3];
	logic signed [CB:0]      diff   [3];
	logic                    load;
	logic                    issue;
	logic                    issue_last;
	logic                    credit;
	logic                    v_s1;
	logic                    last_s1;
	logic [OW-1:0]           oq_q [OUT_DEPTH];
	logic [OPW-1:0]          owp_q;
	logic [OPW-1:0]          orp_q;
	logic [OCW-1:0]          ocnt_q;
	logic                    oread;

	// Offset per axis from the job's bounding box: midpoint or minimum.
	for (genvar a = 0; a < 3; a++) begin : g_off
		logic signed [CB-1:0] lo;
		logic signed [CB-1:0] hi;
		logic signed [CB:0]   sum;

		assign lo  = job_lo[(2-a)*CB +: CB];
		assign hi  = job_hi[(2-a)*CB +: CB];
		assign sum = (CB+1)'(lo) + (CB+1)'(hi);

		always_comb begin
			if (job_flags.mode == OFFSET_MIN) begin
				off_nx[a] = (CB+1)'(lo);
			end else begin
				off_nx[a] = sum >>> 1;
			end
		end

		// Replayed point minus offset, one bit wider so it never wraps.
		assign diff[a] = (CB+1)'($signed(rd_data[(2-a)*CB +: CB])) - off_q[a];
	end

	// Issue a read only when the result queue has room for it and the one in flight.
	assign credit     = ((OCW+1)'(ocnt_q) + (OCW+1)'(v_s1)) < (OCW+1)'(OUT_DEPTH);
	assign issue_last = (idx_q == CNT_W'(cnt_q - 1'b1));

	// Next state of the replay sequencer.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					state_nx = BK_RUN;
				end
			end
			BK_RUN: begin
				if (credit && issue_last) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		load    = 1'b0;
		issue   = 1'b0;
		job_pop = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				load = job_valid;
			end
			BK_RUN: begin
				issue   = credit;
				job_pop = credit & issue_last;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	assign rd_en   = issue;
	assign rd_addr = {bank_q, idx_q[AW-1:0]};

	// Sequencer control state and the read pipeline's valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_nx;
			v_s1    <= issue;
			if (load) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= CNT_W'(idx_q + 1'b1);
			end
		end
	end

	// Job context taken when the replay starts.
	always_ff @(posedge clk) begin
		if (load) begin
			cnt_q     <= job_count;
			bank_q    <= job_flags.bank;
			dropped_q <= job_flags.dropped;
			for (int a = 0; a < 3; a++) begin
				off_q[a] <= off_nx[a];
			end
		end
		if (issue) begin
			last_s1 <= issue_last;
		end
	end

	// Result queue between the replay and the consumer.
	assign oread = pop & ~empty;
	assign empty = (ocnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s1) begin
				owp_q <= OPW'(owp_q + 1'b1);
			end
			if (oread) begin
				orp_q <= OPW'(orp_q + 1'b1);
			end
			ocnt_q <= OCW'(ocnt_q + OCW'(v_s1) - OCW'(oread));
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			oq_q[owp_q] <= {diff[0], diff[1], diff[2], last_s1, dropped_q};
		end
	end

	assign {out_x, out_y, out_z, out_last, dropped_points} = oq_q[orp_q];

endmodule

>>> rtl/point_cloud_bbox_recenter.sv
// Channel   Direction  Handshake                Payload
// input     in         push / full              in_x, in_y, in_z, in_last
// result    out        pop / empty              out_x, out_y, out_z, out_last, dropped_points
// config    in         cfg_valid / cfg_ready    cfg_data (offset mode)
//
// Points are taken one per cycle while full is low; a cloud's replay then yields one
// result per cycle while the result queue has room, set by the single read port of
// the point buffer. The buffer has two banks, so a new cloud loads while the previous
// one replays; full rises only when both banks hold clouds not yet fully replayed.
// A replay loads its job in the idle state and issues reads from the run state; a
// stalled pop holds results in a four-entry queue and pauses buffer reads.
// Reset clears the counters and sequencer; the point buffer needs no clearing.
module point_cloud_bbox_recenter #(
	parameter int MAX_POINTS = pcbr_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = pcbr_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] in_x,
	input  logic signed [COORD_BITS-1:0] in_y,
	input  logic signed [COORD_BITS-1:0] in_z,
	input  logic                         in_last,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS:0]   out_x,
	output logic signed [COORD_BITS:0]   out_y,
	output logic signed [COORD_BITS:0]   out_z,
	output logic                         out_last,
	output logic                         dropped_points,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data
);

	import pcbr_pkg::*;

	localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int PW     = 3 * COORD_BITS;
	localparam int FW     = $bits(job_flags_t);
	localparam int JOB_W  = FW + CNT_W + 2 * PW;

	job_flags_t        f_flags;
	logic [CNT_W-1:0]  f_count;
	logic [PW-1:0]     f_lo;
	logic [PW-1:0]     f_hi;
	logic              f_push;
	job_flags_t        q_flags;
	logic [CNT_W-1:0]  q_count;
	logic [PW-1:0]     q_lo;
	logic [PW-1:0]     q_hi;
	logic [JOB_W-1:0]  q_head;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic              wr_en;
	logic [AW:0]       wr_addr;
	logic [PW-1:0]     wr_data;
	logic              rd_en;
	logic [AW:0]       rd_addr;
	logic [PW-1:0]     rd_data;

	// The user writes the register only while the block is idle; the block does not enforce it, so it is always ready.
	assign cfg_ready = 1'b1;

	// Intake: buffering, bounding box and job hand-off.
	pcbr_front #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.in_last   (in_last),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.job_full  (q_full),
		.job_push  (f_push),
		.job_flags (f_flags),
		.job_count (f_count),
		.job_lo    (f_lo),
		.job_hi    (f_hi),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Job queue, one slot per buffer bank.
	pcbr_jobq #(
		.DATA_W (JOB_W)
	) u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_flags, f_count, f_lo, f_hi}),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	assign {q_flags, q_count, q_lo, q_hi} = q_head;

	// Two-bank point buffer.
	pcbr_store #(
		.ADDR_W (AW + 1),
		.DATA_W (PW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Replay with offset subtraction and result queue.
	pcbr_back #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (q_valid),
		.job_flags      (q_flags),
		.job_count      (q_count),
		.job_lo         (q_lo),
		.job_hi         (q_hi),
		.job_pop        (q_pop),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.empty          (empty),
		.pop            (pop),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_z          (out_z),
		.out_last       (out_last),
		.dropped_points (dropped_points)
	);

endmodule

>>> dv/tb_point_cloud_bbox_recenter.sv
`timescale 1ns / 1ps

module tb_point_cloud_bbox_recenter;
	import pcbr_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;
	localparam int CB   = COORD_BITS_DEF;
	// Cycles allowed for the back end to settle after the last result of a cloud.
	localparam int SETTLE_CYCLES = 12;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [CB:0]   wide_t;

	typedef struct packed {
		logic signed [CB:0] x;
		logic signed [CB:0] y;
		logic signed [CB:0] z;
		logic               last;
		logic               dropped;
	} recentred_pt_t;

	localparam coord_t C_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(CB-1){1'b0}}};

	logic   clk;
	logic   arst_n;
	logic   push;
	logic   full;
	coord_t in_x;
	coord_t in_y;
	coord_t in_z;
	logic   in_last;
	logic   empty;
	logic   pop;
	wide_t  out_x;
	wide_t  out_y;
	wide_t  out_z;
	logic   out_last;
	logic   dropped_points;
	logic   cfg_valid;
	logic   cfg_ready;
	logic   cfg_data;

	point_cloud_bbox_recenter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.in_x           (in_x),
		.in_y           (in_y),
		.in_z           (in_z),
		.in_last        (in_last),
		.empty          (empty),
		.pop            (pop),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_z          (out_z),
		.out_last       (out_last),
		.dropped_points (dropped_points),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	// Predictor state: the cloud being loaded, its bounding box and the offset mode.
	coord_t cloud_pts [NPTS][3];
	coord_t box_lo [3];
	coord_t box_hi [3];
	int     cloud_len;
	logic   cloud_lost;
	logic   offset_sel;

	recentred_pt_t recentred_q [$];

	int err_count;
	int result_idx;
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold;
	int rx_gap;
	int random_items;

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Every input is known from time zero.
	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		in_x        = '0;
		in_y        = '0;
		in_z        = '0;
		in_last     = 1'b0;
		pop         = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = OFFSET_CENTRE;
		err_count   = 0;
		result_idx  = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold     = 0;
		rx_gap      = 0;
		cloud_len   = 0;
		cloud_lost  = 1'b0;
		offset_sel  = OFFSET_CENTRE;
	end

	function automatic wide_t widen(coord_t v);
		wide_t w;
		w = v;
		return w;
	endfunction

	// A gap is drawn with the given percent chance; most gaps are short, now and then one is long.
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Coordinates lean towards the extremes and small values now and then.
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return C_MAX;
			1: return C_MIN;
			2, 3: return coord_t'($urandom_range(0, 200)) - coord_t'(100);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Absorb one accepted point; a last point queues the whole recentred cloud.
	function automatic void absorb_point(coord_t x, coord_t y, coord_t z, logic last);
		coord_t        p [3];
		wide_t         off [3];
		wide_t         sum;
		recentred_pt_t r;
		p[0] = x;
		p[1] = y;
		p[2] = z;
		if (cloud_len < NPTS) begin
			for (int a = 0; a < 3; a++) begin
				cloud_pts[cloud_len][a] = p[a];
				if (cloud_len == 0 || p[a] < box_lo[a])
					box_lo[a] = p[a];
				if (cloud_len == 0 || p[a] > box_hi[a])
					box_hi[a] = p[a];
			end
			cloud_len++;
		end else begin
			cloud_lost = 1'b1;
		end
		if (!last)
			return;
		for (int a = 0; a < 3; a++) begin
			sum    = widen(box_lo[a]) + widen(box_hi[a]);
			off[a] = (offset_sel == OFFSET_MIN) ? widen(box_lo[a]) : (sum >>> 1);
		end
		for (int i = 0; i < cloud_len; i++) begin
			r.x       = widen(cloud_pts[i][0]) - off[0];
			r.y       = widen(cloud_pts[i][1]) - off[1];
			r.z       = widen(cloud_pts[i][2]) - off[2];
			r.last    = (i == cloud_len - 1);
			r.dropped = cloud_lost;
			recentred_q.push_back(r);
		end
		cloud_len  = 0;
		cloud_lost = 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_count++;
	endtask

	// Offer one point from a falling edge and hold it until it is accepted.
	task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
			input logic last);
		int gap;
		gap = pick_gap(tx_idle_pct);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push    <= 1'b1;
		in_x    <= x;
		in_y    <= y;
		in_z    <= z;
		in_last <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		absorb_point(x, y, z, last);
		@(negedge clk);
	endtask

	// Send a cloud of random points; the final one carries the last mark.
	task automatic send_random_cloud(input int len);
		for (int i = 0; i < len; i++)
			send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
	endtask

	// Change the offset mode once every result has drained and the block has settled.
	task automatic write_mode(input logic m);
		push <= 1'b0;
		while (recentred_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		offset_sel = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: pop with random gaps, or hold off for a counted stretch.
	always @(negedge clk) begin : rx_drive
		int gap;
		if (rx_hold > 0) begin
			pop <= 1'b0;
			rx_hold--;
		end else if (rx_gap > 0) begin
			pop <= 1'b0;
			rx_gap--;
		end else begin
			gap = pick_gap(rx_idle_pct);
			if (gap > 0) begin
				pop    <= 1'b0;
				rx_gap = gap - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest expected one.
	always @(posedge clk) begin : result_check
		recentred_pt_t e;
		if (arst_n && pop && !empty) begin
			if (recentred_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					result_idx));
			end else begin
				e = recentred_q.pop_front();
				if (out_x !== e.x)
					report_mismatch($sformatf("result %0d out_x %0d, expected %0d",
						result_idx, out_x, e.x));
				if (out_y !== e.y)
					report_mismatch($sformatf("result %0d out_y %0d, expected %0d",
						result_idx, out_y, e.y));
				if (out_z !== e.z)
					report_mismatch($sformatf("result %0d out_z %0d, expected %0d",
						result_idx, out_z, e.z));
				if (out_last !== e.last)
					report_mismatch($sformatf("result %0d out_last %b, expected %b",
						result_idx, out_last, e.last));
				if (dropped_points !== e.dropped)
					report_mismatch($sformatf("result %0d dropped_points %b, expected %b",
						result_idx, dropped_points, e.dropped));
			end
			result_idx++;
		end
	end

	// Extremes, odd sums that round down, a single-point cloud, in both modes.
	task automatic test_directed();
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		for (int m = 0; m < 2; m++) begin
			write_mode(m == 0 ? OFFSET_CENTRE : OFFSET_MIN);
			send_point(C_MAX, C_MIN, coord_t'(0), 1'b0);
			send_point(C_MIN, C_MAX, coord_t'(-1), 1'b0);
			send_point(coord_t'(0), coord_t'(-1), coord_t'(1), 1'b0);
			send_point(coord_t'(-3), coord_t'(5), coord_t'(7), 1'b0);
			send_point(coord_t'(3), coord_t'(-5), C_MAX, 1'b1);
			send_point(C_MIN, C_MAX, coord_t'(-1), 1'b1);
			send_point(coord_t'(-3), coord_t'(-1), C_MIN, 1'b0);
			send_point(coord_t'(0), coord_t'(0), C_MIN + coord_t'(1), 1'b1);
		end
	endtask

	// A cloud that fills the buffer exactly, then two whose overflow, last point included, is dropped.
	task automatic test_buffer_full();
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		write_mode(OFFSET_CENTRE);
		send_random_cloud(NPTS);
		send_random_cloud(NPTS + 3);
		write_mode(OFFSET_MIN);
		send_random_cloud(NPTS + 1);
	endtask

	// The receiver holds off while clouds keep coming, so both banks fill and full rises.
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_hold     = 400;
		for (int c = 0; c < 4; c++)
			send_random_cloud(12);
	endtask

	// Random clouds over several mode phases; most clouds are small.
	task automatic test_random();
		int len;
		int pick;
		random_items = 0;
		while (random_items < 100) begin
			write_mode($urandom_range(0, 1) ? OFFSET_MIN : OFFSET_CENTRE);
			pick        = $urandom_range(0, 2);
			tx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
			pick        = $urandom_range(0, 2);
			rx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
			for (int c = 0; c < 3; c++) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					len = $urandom_range(1, 8);
				else if (pick < 94)
					len = $urandom_range(9, NPTS - 1);
				else
					len = $urandom_range(NPTS, NPTS + 6);
				send_random_cloud(len);
				random_items += len;
			end
		end
	endtask

	// Drain what is still expected, settle, then give the verdict.
	task automatic finish_run();
		int waited;
		push   <= 1'b0;
		waited = 0;
		while (recentred_q.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		if (recentred_q.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				recentred_q.size()));
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	endtask

	// Test sequence.
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_buffer_full();
		test_backpressure();
		test_random();
		finish_run();
	end

	// Watchdog for a hung run.
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
rtl/pcbr_pkg.sv
rtl/pcbr_store.sv
rtl/pcbr_jobq.sv
rtl/pcbr_front.sv
rtl/pcbr_back.sv
rtl/point_cloud_bbox_recenter.sv
dv/tb_point_cloud_bbox_recenter.sv
